[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the stream hash.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising edge outside reset.
`define DSH_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("dual stream hash check failed");

// The consequent must hold in the cycle in which the antecedent holds.
`define DSH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dual stream hash check failed");

`endif

[hdl/dsh_pkg.sv]
// ----------------------------------------------------------------------------
// Dual stream hash package
// Types, constants and round functions shared by the stream hash modules.
// ----------------------------------------------------------------------------
package dsh_pkg;

   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
   localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

   localparam logic [63:0] KEY_A_LOW_RESET  = 64'h0706050403020100;
   localparam logic [63:0] KEY_A_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
   localparam logic [63:0] KEY_B_LOW_RESET  = 64'h1716151413121110;
   localparam logic [63:0] KEY_B_HIGH_RESET = 64'h1f1e1d1c1b1a1918;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_A_LOW  = 2'd0,
      CSR_KEY_A_HIGH = 2'd1,
      CSR_KEY_B_LOW  = 2'd2,
      CSR_KEY_B_HIGH = 2'd3
   } csr_index_type;

   localparam logic [2:0] STEP_ABSORB = 3'd0;
   localparam logic [2:0] STEP_FOLD   = 3'd1;
   localparam logic [2:0] STEP_PAD    = 3'd2;
   localparam logic [2:0] STEP_LAST   = 3'd5;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_COMPRESS,
      BK_FINAL
   } back_state_type;

   typedef logic [3:0][63:0] sip_state_type;

   typedef struct packed {
      logic [63:0] a_low;
      logic [63:0] a_high;
      logic [63:0] b_low;
      logic [63:0] b_high;
   } key_set_type;

   typedef struct packed {
      logic        comp;
      logic        fin;
      logic [63:0] word;
      logic [63:0] fin_word;
   } job_type;

   typedef struct packed {
      logic [63:0] hash_a;
      logic [63:0] hash_b;
   } digest_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic sip_state_type sip_init(input logic [63:0] k0, input logic [63:0] k1);
      sip_state_type v;
      v[0] = SIP_C0 ^ k0;
      v[1] = SIP_C1 ^ k1;
      v[2] = SIP_C2 ^ k0;
      v[3] = SIP_C3 ^ k1;
      return v;
   endfunction

   function automatic sip_state_type sip_round(input sip_state_type v_in);
      sip_state_type v;
      v = v_in;
      v[0] = v[0] + v[1];
      v[1] = rotl(v[1], 13);
      v[1] = v[1] ^ v[0];
      v[0] = rotl(v[0], 32);
      v[2] = v[2] + v[3];
      v[3] = rotl(v[3], 16);
      v[3] = v[3] ^ v[2];
      v[0] = v[0] + v[3];
      v[3] = rotl(v[3], 21);
      v[3] = v[3] ^ v[0];
      v[2] = v[2] + v[1];
      v[1] = rotl(v[1], 17);
      v[1] = v[1] ^ v[2];
      v[2] = rotl(v[2], 32);
      return v;
   endfunction

endpackage

[hdl/dsh_fifo.sv]
// ----------------------------------------------------------------------------
// Stream hash queue
// Small first-in first-out buffer built from registers.
// ----------------------------------------------------------------------------
module dsh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/dsh_front.sv]
// ----------------------------------------------------------------------------
// Stream hash front end
// Gathers message bytes into words and queues compression and finalisation
// jobs for the round engine.
// ----------------------------------------------------------------------------
module dsh_front
   import dsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        restart,
   input  logic        accept,
   input  logic [63:0] data_word,
   input  logic [3:0]  byte_count,
   input  logic        last,
   output logic        job_push,
   output job_type     job
);

   logic [55:0] pend_ff, pend_in;
   logic [2:0]  count_ff, count_in;
   logic [7:0]  len_ff, len_in;

   logic [3:0]  n;
   logic [63:0] data_m;
   logic [3:0]  sum;
   logic [63:0] shifted;
   logic [63:0] word;
   logic [63:0] carry;
   logic [6:0]  hi_shift;
   logic        word_done;
   logic [55:0] pend_upd;
   logic [2:0]  count_upd;
   logic [7:0]  len_upd;

   always_comb begin
      n = (byte_count > 4'd8) ? 4'd8 : byte_count;
      for (int i = 0; i < 8; i++) begin
         data_m[8*i +: 8] = (4'(i) < n) ? data_word[8*i +: 8] : 8'd0;
      end
      sum       = {1'b0, count_ff} + n;
      shifted   = data_m << {count_ff, 3'b000};
      word      = {8'd0, pend_ff} | shifted;
      hi_shift  = {4'd8 - {1'b0, count_ff}, 3'b000};
      carry     = (count_ff == 3'd0) ? 64'd0 : (data_m >> hi_shift);
      word_done = (n != 4'd0) && sum[3];
      if (n == 4'd0) begin
         pend_upd  = pend_ff;
         count_upd = count_ff;
         len_upd   = len_ff;
      end else begin
         pend_upd  = sum[3] ? carry[55:0] : word[55:0];
         count_upd = sum[2:0];
         len_upd   = len_ff + {4'd0, n};
      end
   end

   assign job_push     = accept & (word_done | last);
   assign job.comp     = word_done;
   assign job.fin      = last;
   assign job.word     = word;
   assign job.fin_word = {len_upd, pend_upd};

   always_comb begin
      pend_in  = pend_ff;
      count_in = count_ff;
      len_in   = len_ff;
      if (restart) begin
         pend_in  = '0;
         count_in = '0;
         len_in   = '0;
      end else if (accept) begin
         if (last) begin
            pend_in  = '0;
            count_in = '0;
            len_in   = '0;
         end else begin
            pend_in  = pend_upd;
            count_in = count_upd;
            len_in   = len_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         count_ff <= '0;
         len_ff   <= '0;
      end else begin
         pend_ff  <= pend_in;
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

endmodule

[hdl/dsh_core.sv]
// ----------------------------------------------------------------------------
// Stream hash round engine
// Runs one SipRound per cycle for each keyed instance unless idle or held by
// a full result queue, absorbing queued words and finalising both digests.
// ----------------------------------------------------------------------------
module dsh_core
   import dsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        restart,
   input  key_set_type keys,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_pop,
   input  logic        rsp_full,
   output logic        rsp_push,
   output digest_type  digest
);

   back_state_type state_ff, state_in;
   logic [2:0]     cnt_ff, cnt_in;
   job_type        job_ff;
   sip_state_type  va_ff, vb_ff;

   sip_state_type  va_pre, vb_pre, va_post, vb_post;
   sip_state_type  init_a, init_b;
   logic [63:0]    absorb_word;
   logic           load;
   logic           finish;
   logic           advance;

   assign init_a = sip_init(keys.a_low, keys.a_high);
   assign init_b = sip_init(keys.b_low, keys.b_high);
   assign absorb_word = (state_ff == BK_COMPRESS) ? job_ff.word : job_ff.fin_word;

   always_comb begin
      va_pre = va_ff;
      vb_pre = vb_ff;
      if (cnt_ff == STEP_ABSORB) begin
         va_pre[3] = va_ff[3] ^ absorb_word;
         vb_pre[3] = vb_ff[3] ^ absorb_word;
      end else if ((state_ff == BK_FINAL) && (cnt_ff == STEP_PAD)) begin
         va_pre[2] = va_ff[2] ^ FIN_XOR;
         vb_pre[2] = vb_ff[2] ^ FIN_XOR;
      end
      va_post = sip_round(va_pre);
      vb_post = sip_round(vb_pre);
      if (cnt_ff == STEP_FOLD) begin
         va_post[0] = va_post[0] ^ absorb_word;
         vb_post[0] = vb_post[0] ^ absorb_word;
      end
   end

   assign digest.hash_a = va_post[0] ^ va_post[1] ^ va_post[2] ^ va_post[3];
   assign digest.hash_b = vb_post[0] ^ vb_post[1] ^ vb_post[2] ^ vb_post[3];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      load     = 1'b0;
      finish   = 1'b0;
      advance  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            load = job_valid;
         end
         BK_COMPRESS: begin
            advance = 1'b1;
            if (cnt_ff == STEP_ABSORB) begin
               cnt_in = STEP_FOLD;
            end else if (job_ff.fin) begin
               state_in = BK_FINAL;
               cnt_in   = STEP_ABSORB;
            end else begin
               finish = 1'b1;
            end
         end
         BK_FINAL: begin
            if (cnt_ff != STEP_LAST) begin
               advance = 1'b1;
               cnt_in  = cnt_ff + 3'd1;
            end else if (!rsp_full) begin
               rsp_push = 1'b1;
               finish   = 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (finish) begin
         if (job_valid) begin
            load = 1'b1;
         end else begin
            state_in = BK_IDLE;
         end
      end
      if (load) begin
         job_pop  = 1'b1;
         state_in = job.comp ? BK_COMPRESS : BK_FINAL;
         cnt_in   = STEP_ABSORB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff   <= STEP_ABSORB;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
      if (restart || rsp_push) begin
         va_ff <= init_a;
         vb_ff <= init_b;
      end else if (advance) begin
         va_ff <= va_post;
         vb_ff <= vb_post;
      end
   end

endmodule

[hdl/dual_siphash_stream_hash.sv]
// ----------------------------------------------------------------------------
// Dual keyed stream hash
// Two SipHash-2-4 instances under separate 128-bit keys hash one byte stream.
//
// Items are pushed on the req_ channel while req_full is low; each carries up
// to eight little-endian bytes and a last flag. The front end packs bytes into
// 64-bit words and queues a job per completed word and per message end. The
// round engine runs one SipRound per cycle per instance while it works on a
// job and is not held; the front end keeps taking items while the job queue
// has room. For a final item the engine absorbs the closing length word and
// runs the finalisation rounds before its digest enters the result queue.
// Results are read from the rsp_ channel while rsp_empty is low; if the
// receiver stops popping, the result queue fills, the engine holds its last
// finalisation step, the job queue fills and req_full rises. A key write on
// the csr_ port restarts the message from the new keys; it must only be made
// while the block is idle, which the block itself does not enforce. Reset
// loads the default keys, clears all queues and starts an empty message.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_siphash_stream_hash
   import dsh_pkg::*;
#(
   parameter int JOB_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [63:0]                req_data_word,
   input  logic [3:0]                 req_byte_count,
   input  logic                       req_last,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [63:0]                rsp_hash_a,
   output logic [63:0]                rsp_hash_b,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                csr_write_data
);

   localparam int JOB_WIDTH = $bits(job_type);
   localparam int RSP_WIDTH = $bits(digest_type);

   key_set_type keys_ff, keys_in;
   logic        restart_ff;

   logic        req_accept;
   logic        job_push;
   job_type     job_in_q;
   job_type     job_out_q;
   logic        job_full;
   logic        job_valid;
   logic        job_pop;
   logic        rsp_push;
   logic        rsp_full;
   logic        rsp_valid;
   digest_type  digest;
   digest_type  rsp_head;

   assign req_accept = req_push & ~job_full;
   assign req_full   = job_full;

   always_comb begin
      keys_in = keys_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_A_LOW:  keys_in.a_low  = csr_write_data;
            CSR_KEY_A_HIGH: keys_in.a_high = csr_write_data;
            CSR_KEY_B_LOW:  keys_in.b_low  = csr_write_data;
            CSR_KEY_B_HIGH: keys_in.b_high = csr_write_data;
            default:        keys_in        = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff.a_low  <= KEY_A_LOW_RESET;
         keys_ff.a_high <= KEY_A_HIGH_RESET;
         keys_ff.b_low  <= KEY_B_LOW_RESET;
         keys_ff.b_high <= KEY_B_HIGH_RESET;
         restart_ff     <= 1'b1;
      end else begin
         keys_ff        <= keys_in;
         restart_ff     <= csr_write_enable;
      end
   end

   dsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write_enable),
      .accept     (req_accept),
      .data_word  (req_data_word),
      .byte_count (req_byte_count),
      .last       (req_last),
      .job_push   (job_push),
      .job        (job_in_q)
   );

   dsh_fifo #(
      .WIDTH (JOB_WIDTH),
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_q),
      .pop       (job_pop),
      .pop_data  (job_out_q),
      .full      (job_full),
      .not_empty (job_valid)
   );

   dsh_core u_core (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart_ff),
      .keys      (keys_ff),
      .job_valid (job_valid),
      .job       (job_out_q),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .digest    (digest)
   );

   dsh_fifo #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (digest),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .full      (rsp_full),
      .not_empty (rsp_valid)
   );

   assign rsp_empty  = ~rsp_valid;
   assign rsp_hash_a = rsp_head.hash_a;
   assign rsp_hash_b = rsp_head.hash_b;

   `DSH_ASSERT_IMPLIES(a_rsp_no_overflow, clock, reset, rsp_push, !rsp_full)
   `DSH_ASSERT_IMPLIES(a_job_no_underflow, clock, reset, job_pop, job_valid)
   `DSH_ASSERT_IMPLIES(a_last_makes_job, clock, reset, req_accept && req_last, job_push)
   `DSH_ASSERT_HOLDS(a_push_has_room, clock, reset, !(job_push && job_full))

endmodule
